// ----- hdl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared action codes, error codes and the queue entry type.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam logic [3:0] ACT_PUSH       = 4'd0;
  localparam logic [3:0] ACT_ADD        = 4'd1;
  localparam logic [3:0] ACT_SUB        = 4'd2;
  localparam logic [3:0] ACT_MUL        = 4'd3;
  localparam logic [3:0] ACT_DIV        = 4'd4;
  localparam logic [3:0] ACT_MOD        = 4'd5;
  localparam logic [3:0] ACT_DUP        = 4'd6;
  localparam logic [3:0] ACT_SWAP       = 4'd7;
  localparam logic [3:0] ACT_CLEAR      = 4'd8;
  localparam logic [3:0] ACT_PRINT      = 4'd9;
  localparam logic [3:0] ACT_PRINT_SAVE = 4'd10;
  localparam logic [3:0] ACT_RECALL     = 4'd11;
  localparam logic [3:0] ACT_UNKNOWN    = 4'd12;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_EMPTY   = 3'd1;
  localparam logic [2:0] ERR_FULL    = 3'd2;
  localparam logic [2:0] ERR_ZERODIV = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN = 3'd4;

  // Classified token handed from the front end to the executor.
  typedef struct packed {
    logic [3:0]  action;
    logic        known;
    logic [31:0] operand;
  } token_t;

endpackage

// ----- hdl/rpn_front.sv -----
// ----------------------------------------------------------------------------
// RPN front end
// Accepts tokens, classifies them and queues them for the executor.
// ----------------------------------------------------------------------------
module rpn_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_action,
  input  logic signed [31:0]   in_operand,
  output logic                 q_valid,
  input  logic                 q_ready,
  output rpn_pkg::token_t      q_token
);

  // Two-entry queue.
  rpn_pkg::token_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  rpn_pkg::token_t tok;
  logic            push, pop;

  always_comb begin
    tok.action  = in_action;
    tok.known   = (in_action <= rpn_pkg::ACT_RECALL);
    tok.operand = in_operand;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_token  = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= tok;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/rpn_divider.sv -----
// ----------------------------------------------------------------------------
// RPN divider
// Restoring unsigned divider, one quotient bit per cycle, 48-bit dividend.
// ----------------------------------------------------------------------------
module rpn_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient,
  output logic [31:0] remainder
);

  logic [47:0] q_r;
  logic [32:0] rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted   = {rem_r[31:0], q_r[47]};
  assign diff      = shifted - {1'b0, dvs_r};
  assign quotient  = q_r;
  assign remainder = rem_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd48;
        q_r    <= dividend;
        rem_r  <= 33'd0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!diff[32]) begin
          rem_r <= diff;
          q_r   <= {q_r[46:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/rpn_exec.sv -----
// ----------------------------------------------------------------------------
// RPN executor
// Sequences stack pops and pushes and the arithmetic for one token.
// ----------------------------------------------------------------------------
module rpn_exec #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rpn_pkg::token_t      q_token,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_printed,
  output logic signed [31:0]   out_print_value,
  output logic [2:0]           out_error_code
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_POP_B, S_WAIT_B, S_POP_A, S_WAIT_A, S_CALC, S_MUL,
    S_DIV_WAIT, S_PUSH1, S_PUSH2, S_DONE
  } state_t;

  logic [31:0]     stack_mem [STACK_DEPTH];
  logic [31:0]     rd_data_r;
  state_t          state_r;
  logic [PW-1:0]   sp_r;
  logic [3:0]      act_r;
  logic [31:0]     a_r, b_r, res_r, res2_r, last_r;
  logic [2:0]      err_r;
  logic            two_r;
  logic [63:0]     prod_r;
  logic            div_start;
  logic            div_done;
  logic [47:0]     div_q;
  logic [31:0]     div_rem;
  logic            neg_q;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat(input logic neg, input logic [47:0] m);
    if (neg) return (m >= 48'h80000000) ? 32'h80000000 : (32'd0 - m[31:0]);
    return (m > 48'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
  endfunction

  assign q_ready   = (state_r == S_IDLE);
  assign div_start = (state_r == S_CALC) &&
                     (act_r == rpn_pkg::ACT_DIV || act_r == rpn_pkg::ACT_MOD);
  assign neg_q     = a_r[31] ^ b_r[31];

  rpn_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  ({mag(a_r), 16'd0} >> ((act_r == rpn_pkg::ACT_MOD) ? 16 : 0)),
    .divisor   (mag(b_r)),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Stack memory: one write port, registered read of the top entry.
  always_ff @(posedge clk) begin
    if ((state_r == S_PUSH1 || state_r == S_PUSH2) && sp_r < DEPTH_P) begin
      stack_mem[sp_r[AW-1:0]] <= (state_r == S_PUSH1) ? res_r : res2_r;
    end
    rd_data_r <= stack_mem[AW'(sp_r - PW'(1))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sp_r      <= '0;
      last_r    <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            act_r  <= q_token.action;
            err_r  <= rpn_pkg::ERR_NONE;
            a_r    <= 32'd0;
            b_r    <= 32'd0;
            two_r  <= 1'b0;
            if (!q_token.known) begin
              err_r   <= rpn_pkg::ERR_UNKNOWN;
              state_r <= S_DONE;
            end else begin
              case (q_token.action)
                rpn_pkg::ACT_PUSH: begin
                  res_r <= q_token.operand; state_r <= S_PUSH1;
                end
                rpn_pkg::ACT_RECALL: begin
                  res_r <= last_r; state_r <= S_PUSH1;
                end
                rpn_pkg::ACT_CLEAR: begin
                  sp_r <= '0; state_r <= S_DONE;
                end
                default: state_r <= S_POP_B;
              endcase
            end
          end
        end
        S_POP_B: state_r <= S_WAIT_B;
        S_WAIT_B: begin
          if (sp_r != '0 && sp_r <= DEPTH_P) begin
            b_r  <= rd_data_r;
            sp_r <= sp_r - PW'(1);
          end else begin
            if (err_r == rpn_pkg::ERR_NONE) err_r <= rpn_pkg::ERR_EMPTY;
          end
          if (act_r == rpn_pkg::ACT_DUP || act_r == rpn_pkg::ACT_PRINT ||
              act_r == rpn_pkg::ACT_PRINT_SAVE) state_r <= S_CALC;
          else state_r <= S_POP_A;
        end
        S_POP_A: begin
          if ((act_r == rpn_pkg::ACT_DIV || act_r == rpn_pkg::ACT_MOD) &&
              b_r == 32'd0) begin
            if (err_r == rpn_pkg::ERR_NONE) err_r <= rpn_pkg::ERR_ZERODIV;
            state_r <= S_DONE;
          end else begin
            state_r <= S_WAIT_A;
          end
        end
        S_WAIT_A: begin
          if (sp_r != '0 && sp_r <= DEPTH_P) begin
            a_r  <= rd_data_r;
            sp_r <= sp_r - PW'(1);
          end else begin
            if (err_r == rpn_pkg::ERR_NONE) err_r <= rpn_pkg::ERR_EMPTY;
          end
          state_r <= S_CALC;
        end
        S_CALC: begin
          case (act_r)
            rpn_pkg::ACT_ADD: begin
              res_r <= ((a_r[31] == b_r[31]) && ((a_r + b_r) >> 31 != {31'd0, a_r[31]}))
                       ? (a_r[31] ? 32'h80000000 : 32'h7FFFFFFF) : a_r + b_r;
              state_r <= S_PUSH1;
            end
            rpn_pkg::ACT_SUB: begin
              res_r <= ((a_r[31] != b_r[31]) && ((a_r - b_r) >> 31 != {31'd0, a_r[31]}))
                       ? (a_r[31] ? 32'h80000000 : 32'h7FFFFFFF) : a_r - b_r;
              state_r <= S_PUSH1;
            end
            rpn_pkg::ACT_MUL: begin
              prod_r  <= mag(a_r) * mag(b_r);
              state_r <= S_MUL;
            end
            rpn_pkg::ACT_DIV, rpn_pkg::ACT_MOD: state_r <= S_DIV_WAIT;
            rpn_pkg::ACT_DUP: begin
              res_r <= b_r; res2_r <= b_r; two_r <= 1'b1; state_r <= S_PUSH1;
            end
            rpn_pkg::ACT_SWAP: begin
              // The old top goes back first, so the second entry ends on top.
              res_r <= b_r; res2_r <= a_r; two_r <= 1'b1; state_r <= S_PUSH1;
            end
            rpn_pkg::ACT_PRINT_SAVE: begin
              last_r <= b_r; state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_MUL: begin
          res_r   <= (prod_r[63:48] != 16'd0) ? sat(neg_q, 48'hFFFFFFFFFFFF)
                                              : sat(neg_q, prod_r[63:16]);
          state_r <= S_PUSH1;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (act_r == rpn_pkg::ACT_DIV) res_r <= sat(neg_q, div_q);
            else res_r <= a_r[31] ? (32'd0 - div_rem) : div_rem;
            state_r <= S_PUSH1;
          end
        end
        S_PUSH1: begin
          if (sp_r < DEPTH_P) sp_r <= sp_r + PW'(1);
          else if (err_r == rpn_pkg::ERR_NONE) err_r <= rpn_pkg::ERR_FULL;
          state_r <= two_r ? S_PUSH2 : S_DONE;
        end
        S_PUSH2: begin
          if (sp_r < DEPTH_P) sp_r <= sp_r + PW'(1);
          else if (err_r == rpn_pkg::ERR_NONE) err_r <= rpn_pkg::ERR_FULL;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            out_error_code <= err_r;
            out_printed    <= (act_r == rpn_pkg::ACT_PRINT ||
                               act_r == rpn_pkg::ACT_PRINT_SAVE);
            out_print_value <= (act_r == rpn_pkg::ACT_PRINT ||
                                act_r == rpn_pkg::ACT_PRINT_SAVE) ? b_r : 32'd0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid && out_ready && state_r != S_DONE) out_valid <= 1'b0;
    end
  end

endmodule

// ----- hdl/rpn_stack_calculator.sv -----
// Each accepted word gives one result word; divide and remainder run on the
// 48-step divider, and output stalls delay the result word. The executor
// works on one token at a time and takes no new token until the result word
// of the last one is registered; a two-word queue lets the front end take
// tokens while the executor works.
// Reset (rst_n low, synchronous) empties the stack and clears the saved value.
// ----------------------------------------------------------------------------
// RPN stack calculator
// Postfix Q16.16 calculator: front end queue plus stack executor.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_printed,
  output logic signed [31:0] out_print_value,
  output logic [2:0]         out_error_code
);

  // Each accepted word is classified and queued; the executor pops it.
  logic            q_valid, q_ready;
  rpn_pkg::token_t q_token;

  rpn_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_operand(in_operand),
    .q_valid(q_valid), .q_ready(q_ready), .q_token(q_token)
  );

  // The executor owns the stack memory and produces one result word.
  rpn_exec #(.STACK_DEPTH(STACK_DEPTH)) u_exec (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_token(q_token), .out_valid(out_valid), .out_ready(out_ready),
    .out_printed(out_printed), .out_print_value(out_print_value),
    .out_error_code(out_error_code)
  );

endmodule
